>>> hw/rtl/mstt_pkg.sv
// Package for the multi-shot timer table: sizes, codes and time constants.
// No dependencies; used by every module of the block.
package mstt_pkg;
    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [30:0] NS_PER_SEC    = 31'd1000000000;
    localparam logic [30:0] NS_TWO_SEC    = 31'd2000000000;
    localparam logic [39:0] SECS_MAX      = 40'hFF_FFFF_FFFF;
    localparam logic [29:0] NS_MAX        = 30'd999999999;
    localparam logic [15:0] SHOTS_FOREVER = 16'hFFFF;
    localparam logic [29:0] LOOKAHEAD_RST = 30'd100000;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_UNSET   = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_UNSET = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;
    localparam logic [1:0] KIND_SUM   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    typedef struct packed {
        logic [39:0] secs;
        logic [29:0] nsecs;
    } tstamp_t;
endpackage

>>> hw/rtl/mstt_time_unit.sv
// Shared time unit: normalized, saturating add and a less-or-equal compare.
// Depends on mstt_pkg.
module mstt_time_unit (
    input  mstt_pkg::tstamp_t add_a,
    input  mstt_pkg::tstamp_t add_b,
    output mstt_pkg::tstamp_t sum,
    input  mstt_pkg::tstamp_t cmp_a,
    input  mstt_pkg::tstamp_t cmp_b,
    output logic              le
);
    import mstt_pkg::*;

    logic [30:0] ns_raw;
    logic [30:0] ns_norm;
    logic [1:0]  carry;
    logic [41:0] s_raw;

    // Add nanoseconds, then fold the carry of up to two seconds
    always_comb
    begin
        ns_raw = {1'b0, add_a.nsecs} + {1'b0, add_b.nsecs};
        if (ns_raw >= NS_TWO_SEC)
        begin
            ns_norm = ns_raw - NS_TWO_SEC;
            carry   = 2'd2;
        end
        else if (ns_raw >= NS_PER_SEC)
        begin
            ns_norm = ns_raw - NS_PER_SEC;
            carry   = 2'd1;
        end
        else
        begin
            ns_norm = ns_raw;
            carry   = 2'd0;
        end
        s_raw = {2'b00, add_a.secs} + {2'b00, add_b.secs} + {40'd0, carry};
        if (s_raw > {2'b00, SECS_MAX})
        begin
            sum.secs  = SECS_MAX;
            sum.nsecs = NS_MAX;
        end
        else
        begin
            sum.secs  = s_raw[39:0];
            sum.nsecs = ns_norm[29:0];
        end
    end

    // Compare two timestamps
    assign le = (cmp_a.secs < cmp_b.secs) ||
                ((cmp_a.secs == cmp_b.secs) && (cmp_a.nsecs <= cmp_b.nsecs));
endmodule

>>> hw/rtl/multi_shot_timer_table.sv
// Top level of the multi-shot timer table: slot store, sequencer, output register.
// Depends on mstt_pkg and mstt_time_unit.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    mode event_id shots interval_* now_*
// out      output     out_valid / out_ready  kind fired_event status slot_index ...
// cfg      input      cfg_we                 cfg_data (look-ahead, ns)
//
// A set scans every slot, then writes; an unset scans and frees; a refused set goes
// straight to the result. One slot is visited per cycle in a scan.
// A tick adds the look-ahead to now, then makes a count pass and a fire pass of the
// shared time unit: a fired slot is emitted, a pending or reloaded one is min-tracked.
// Reset frees every slot at once; the block is ready as soon as reset is released.
// A stalled output holds the sequencer only when it has the next result ready.
module multi_shot_timer_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] event_id,
    input  logic signed [15:0] shots,
    input  logic [31:0] interval_secs,
    input  logic [29:0] interval_nsecs,
    input  logic [39:0] now_secs,
    input  logic [29:0] now_nsecs,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] fired_event,
    output logic [1:0]  status,
    output logic [3:0]  slot_index,
    output logic [4:0]  removed_count,
    output logic [4:0]  active_count,
    output logic        soonest_valid,
    output logic [39:0] soonest_secs,
    output logic [29:0] soonest_nsecs,
    output logic        last
);
    import mstt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TLA     = 4'd1;
    localparam logic [3:0] S_TCNT    = 4'd2;
    localparam logic [3:0] S_TDUE    = 4'd3;
    localparam logic [3:0] S_TMIN    = 4'd4;
    localparam logic [3:0] S_TADV    = 4'd5;
    localparam logic [3:0] S_SSCAN   = 4'd6;
    localparam logic [3:0] S_SWRITE  = 4'd7;
    localparam logic [3:0] S_USCAN   = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // slot store
    logic [15:0] shots_reg  [SLOTS];
    logic [15:0] event_reg  [SLOTS];
    tstamp_t     next_reg   [SLOTS];
    tstamp_t     period_reg [SLOTS];

    logic [3:0]       state_reg;
    logic [3:0]       ret_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] active_reg;
    logic [CNT_W-1:0] final_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [29:0]      lookahead_reg;

    logic [15:0] ev_reg;
    logic [15:0] in_shots_reg;
    tstamp_t     delay_reg;
    tstamp_t     now_reg;
    tstamp_t     ts_reg;
    tstamp_t     ss_reg;
    logic        sv_reg;
    logic        match_ok_reg;
    logic        free_ok_reg;
    logic [IDX_W-1:0] match_reg;
    logic [IDX_W-1:0] free_reg;

    // pending result
    logic [1:0]  res_kind_reg;
    logic [15:0] res_ev_reg;
    logic [1:0]  res_status_reg;
    logic [3:0]  res_slot_reg;
    logic [4:0]  res_removed_reg;
    logic [4:0]  res_active_reg;
    logic        res_sv_reg;
    tstamp_t     res_ss_reg;
    logic        res_last_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  o_kind_reg;
    logic [15:0] o_ev_reg;
    logic [1:0]  o_status_reg;
    logic [3:0]  o_slot_reg;
    logic [4:0]  o_removed_reg;
    logic [4:0]  o_active_reg;
    logic        o_sv_reg;
    tstamp_t     o_ss_reg;
    logic        o_last_reg;

    tstamp_t     add_a, add_b, sum, cmp_a, cmp_b;
    logic        le;
    logic        cur_act;
    logic [15:0] shots_dec;
    logic        out_free;
    logic [IDX_W-1:0] set_slot;
    logic        set_ok;
    logic [SLOTS-1:0] act_mask;

    mstt_time_unit u_time (
        .add_a (add_a),
        .add_b (add_b),
        .sum   (sum),
        .cmp_a (cmp_a),
        .cmp_b (cmp_b),
        .le    (le)
    );

    // Route operands of the shared unit by state
    always_comb
    begin
        add_a = next_reg[idx_reg];
        add_b = period_reg[idx_reg];
        cmp_a = next_reg[idx_reg];
        cmp_b = ts_reg;
        case (state_reg)
            S_TLA:
            begin
                add_a = now_reg;
                add_b = '{secs: 40'd0, nsecs: lookahead_reg};
            end
            S_SWRITE:
            begin
                add_a = now_reg;
                add_b = delay_reg;
            end
            S_TMIN:
            begin
                cmp_a = ss_reg;
                cmp_b = next_reg[idx_reg];
            end
            default:
            begin
            end
        endcase
    end

    assign cur_act   = (shots_reg[idx_reg] != 16'd0);
    assign shots_dec = (shots_reg[idx_reg] == SHOTS_FOREVER) ? SHOTS_FOREVER
                                                             : shots_reg[idx_reg] - 16'd1;
    assign out_free  = !out_valid_reg || out_ready;
    assign set_ok    = match_ok_reg || free_ok_reg;
    assign set_slot  = match_ok_reg ? match_reg : free_reg;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            act_mask[i] = (shots_reg[i] != 16'd0);
        end
    end

    // Write slot payload (no reset: read only for active slots)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SWRITE && set_ok)
        begin
            event_reg[set_slot]  <= ev_reg;
            period_reg[set_slot] <= delay_reg;
            next_reg[set_slot]   <= sum;
        end
        else if (state_reg == S_TDUE && cur_act && le && shots_dec != 16'd0)
        begin
            next_reg[idx_reg] <= sum;
        end
    end

    // Sequencer, shot counts and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shots_reg[i] <= 16'd0;
            end
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            final_reg     <= '0;
            cnt_reg       <= '0;
            lookahead_reg <= LOOKAHEAD_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lookahead_reg <= cfg_data;
            end
            // drop a taken result unless the next one replaces it
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ev_reg       <= event_id;
                        in_shots_reg <= shots;
                        delay_reg    <= '{secs: {8'd0, interval_secs}, nsecs: interval_nsecs};
                        now_reg      <= '{secs: now_secs, nsecs: now_nsecs};
                        idx_reg      <= '0;
                        cnt_reg      <= '0;
                        match_ok_reg <= 1'b0;
                        free_ok_reg  <= 1'b0;
                        sv_reg       <= 1'b0;
                        res_ev_reg      <= event_id;
                        res_status_reg  <= ST_OK;
                        res_slot_reg    <= 4'd0;
                        res_removed_reg <= 5'd0;
                        res_sv_reg      <= 1'b0;
                        res_ss_reg      <= '0;
                        res_last_reg    <= 1'b0;
                        case (mode)
                            MODE_TICK:  state_reg <= S_TLA;
                            MODE_SET:
                            begin
                                if (shots == 16'sd0)
                                begin
                                    res_kind_reg   <= KIND_SET;
                                    res_status_reg <= ST_ZERO;
                                    res_active_reg <= 5'(active_reg);
                                    res_last_reg   <= 1'b1;
                                    ret_reg        <= S_IDLE;
                                    state_reg      <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_SSCAN;
                                end
                            end
                            MODE_UNSET: state_reg <= S_USCAN;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_TLA:
                begin
                    ts_reg    <= sum;
                    state_reg <= S_TCNT;
                end
                // count slots that run out on this tick
                S_TCNT:
                begin
                    if (cur_act && le && shots_reg[idx_reg] == 16'd1)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        final_reg <= (cnt_reg + CNT_W'(cur_act && le
                                     && shots_reg[idx_reg] == 16'd1) > active_reg)
                                     ? '0
                                     : active_reg - cnt_reg - CNT_W'(cur_act && le
                                       && shots_reg[idx_reg] == 16'd1);
                        idx_reg   <= '0;
                        state_reg <= S_TDUE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                // fire a due slot and reload it unless it has run out
                S_TDUE:
                begin
                    if (!cur_act)
                    begin
                        state_reg <= S_TADV;
                    end
                    else if (le)
                    begin
                        shots_reg[idx_reg] <= shots_dec;
                        res_kind_reg   <= KIND_FIRED;
                        res_ev_reg     <= event_reg[idx_reg];
                        res_slot_reg   <= 4'(idx_reg);
                        res_active_reg <= 5'(final_reg);
                        res_last_reg   <= 1'b0;
                        ret_reg        <= (shots_dec == 16'd0) ? S_TADV : S_TMIN;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_TMIN;
                    end
                end
                // track the soonest pending deadline
                S_TMIN:
                begin
                    if (!sv_reg || !le)
                    begin
                        ss_reg <= next_reg[idx_reg];
                        sv_reg <= 1'b1;
                    end
                    state_reg <= S_TADV;
                end
                S_TADV:
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        active_reg      <= final_reg;
                        res_kind_reg    <= KIND_SUM;
                        res_ev_reg      <= 16'd0;
                        res_slot_reg    <= 4'd0;
                        res_active_reg  <= 5'(final_reg);
                        res_sv_reg      <= sv_reg;
                        res_ss_reg      <= sv_reg ? ss_reg : '0;
                        res_last_reg    <= 1'b1;
                        ret_reg         <= S_IDLE;
                        state_reg       <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_TDUE;
                    end
                end
                // look for a matching active slot and the lowest free one
                S_SSCAN:
                begin
                    if (cur_act && event_reg[idx_reg] == ev_reg && !match_ok_reg)
                    begin
                        match_ok_reg <= 1'b1;
                        match_reg    <= idx_reg;
                    end
                    if (!cur_act && !free_ok_reg)
                    begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= idx_reg;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= S_SWRITE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_SWRITE:
                begin
                    res_kind_reg <= KIND_SET;
                    res_last_reg <= 1'b1;
                    ret_reg      <= S_IDLE;
                    state_reg    <= S_EMIT;
                    if (set_ok)
                    begin
                        shots_reg[set_slot] <= in_shots_reg;
                        res_slot_reg        <= 4'(set_slot);
                        if (!match_ok_reg)
                        begin
                            active_reg     <= active_reg + CNT_W'(1);
                            res_active_reg <= 5'(active_reg + CNT_W'(1));
                        end
                        else
                        begin
                            res_active_reg <= 5'(active_reg);
                        end
                    end
                    else
                    begin
                        res_status_reg <= ST_NO_FREE;
                        res_active_reg <= 5'(active_reg);
                    end
                end
                // free every active slot with this id
                S_USCAN:
                begin
                    if (cur_act && event_reg[idx_reg] == ev_reg)
                    begin
                        shots_reg[idx_reg] <= 16'd0;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        res_kind_reg    <= KIND_UNSET;
                        res_last_reg    <= 1'b1;
                        ret_reg         <= S_IDLE;
                        state_reg       <= S_EMIT;
                        res_removed_reg <= 5'(cnt_reg + CNT_W'(cur_act
                                           && event_reg[idx_reg] == ev_reg));
                        if (cnt_reg + CNT_W'(cur_act && event_reg[idx_reg] == ev_reg)
                            > active_reg)
                        begin
                            active_reg     <= '0;
                            res_active_reg <= 5'd0;
                        end
                        else
                        begin
                            active_reg     <= active_reg - cnt_reg
                                              - CNT_W'(cur_act && event_reg[idx_reg] == ev_reg);
                            res_active_reg <= 5'(active_reg - cnt_reg
                                              - CNT_W'(cur_act && event_reg[idx_reg] == ev_reg));
                        end
                    end
                    else
                    begin
                        if (cur_act && event_reg[idx_reg] == ev_reg)
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                // hand the pending result to the output register
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_kind_reg    <= res_kind_reg;
                        o_ev_reg      <= res_ev_reg;
                        o_status_reg  <= res_status_reg;
                        o_slot_reg    <= res_slot_reg;
                        o_removed_reg <= res_removed_reg;
                        o_active_reg  <= res_active_reg;
                        o_sv_reg      <= res_sv_reg;
                        o_ss_reg      <= res_ss_reg;
                        o_last_reg    <= res_last_reg;
                        state_reg     <= ret_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = o_kind_reg;
    assign fired_event   = o_ev_reg;
    assign status        = o_status_reg;
    assign slot_index    = o_slot_reg;
    assign removed_count = o_removed_reg;
    assign active_count  = o_active_reg;
    assign soonest_valid = o_sv_reg;
    assign soonest_secs  = o_ss_reg.secs;
    assign soonest_nsecs = o_ss_reg.nsecs;
    assign last          = o_last_reg;

    // Active total never exceeds the slot count
    a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= CNT_W'(SLOTS))
        else $error("active total above slot count");

    // Between items the active total matches the active slots
    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(act_mask) == int'(active_reg)))
        else $error("active total out of step with slots");

    // An unknown mode item yields no work
    a_mode_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_IGNORED) |=> (state_reg == S_IDLE))
        else $error("unknown mode item started work");
endmodule
